// File: sv/lrpw_pkg.sv
// ----------------------------------------------------------------------------
// lrpw_pkg: shared types and constants of the line rasterizer pixel writer
// Request payloads, register indexes and the configuration register bundle.
// ----------------------------------------------------------------------------
package lrpw_pkg;

	localparam int COORD_BITS = 8;
	localparam int COLOR_BITS = 16;
	localparam int INDEX_BITS = 16;
	localparam int REG_IDX_BITS = 3;
	// The combined error term can reach about 1.5 times the largest delta in
	// either direction, so it carries two bits beyond a coordinate.
	localparam int ERR_BITS = COORD_BITS + 2;

	localparam logic [COLOR_BITS-1:0] WHITE_565 = 16'hFFFF;
	localparam logic [COLOR_BITS-1:0] COLOR_CODE_FG = 16'h0001;
	localparam logic [COLOR_BITS-1:0] COLOR_CODE_BG = 16'h0000;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_START = 1'b1;

	localparam logic [COORD_BITS-1:0] RST_FRAME_WIDTH = 8'd160;
	localparam logic [COORD_BITS-1:0] RST_FRAME_HEIGHT = 8'd80;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_FRAME_WIDTH      = 3'd0,
		REG_FRAME_HEIGHT     = 3'd1,
		REG_OVERRIDE_COLOR   = 3'd2,
		REG_TEXT_COLOR       = 3'd3,
		REG_BACKGROUND_COLOR = 3'd4
	} lrpw_reg_idx_t;

	typedef struct packed {
		logic                  cmd;
		logic [COORD_BITS-1:0] x_start;
		logic [COORD_BITS-1:0] y_start;
		logic [COORD_BITS-1:0] x_end;
		logic [COORD_BITS-1:0] y_end;
		logic [COLOR_BITS-1:0] color;
	} lrpw_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
		logic [INDEX_BITS-1:0] pixel_index;
		logic [COLOR_BITS-1:0] pixel_color;
		logic                  write_enable;
		logic                  last;
		logic                  busy_res;
	} lrpw_pixel_t;

	typedef struct packed {
		logic [REG_IDX_BITS-1:0] reg_index;
		logic [COLOR_BITS-1:0]   wr_data;
	} lrpw_cfg_wr_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] frame_width;
		logic [COORD_BITS-1:0] frame_height;
		logic [COLOR_BITS-1:0] override_color;
		logic [COLOR_BITS-1:0] text_color;
		logic [COLOR_BITS-1:0] background_color;
	} lrpw_regs_t;

endpackage

// File: sv/lrpw_stream_if.sv
// ----------------------------------------------------------------------------
// lrpw_stream_if: valid/ready channel carrying one request payload
// The source drives valid and data, the sink drives ready.
// ----------------------------------------------------------------------------
interface lrpw_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/lrpw_cfg_regs.sv
// ----------------------------------------------------------------------------
// lrpw_cfg_regs: configuration register file
// Takes register writes by index; writes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module lrpw_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	lrpw_stream_if.sink         cfg,
	output lrpw_pkg::lrpw_regs_t regs
);
	import lrpw_pkg::*;

	lrpw_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.frame_width <= RST_FRAME_WIDTH;
			regs_q.frame_height <= RST_FRAME_HEIGHT;
			regs_q.override_color <= '0;
			regs_q.text_color <= '0;
			regs_q.background_color <= '0;
		end else if (cfg.valid) begin
			case (cfg.data.reg_index)
				REG_FRAME_WIDTH: begin
					regs_q.frame_width <= cfg.data.wr_data[COORD_BITS-1:0];
				end
				REG_FRAME_HEIGHT: begin
					regs_q.frame_height <= cfg.data.wr_data[COORD_BITS-1:0];
				end
				REG_OVERRIDE_COLOR: begin
					regs_q.override_color <= cfg.data.wr_data;
				end
				REG_TEXT_COLOR: begin
					regs_q.text_color <= cfg.data.wr_data;
				end
				REG_BACKGROUND_COLOR: begin
					regs_q.background_color <= cfg.data.wr_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: sv/lrpw_walk.sv
// ----------------------------------------------------------------------------
// lrpw_walk: Bresenham walk state and single-step pixel logic
// Builds the pixel for one request and advances the walk when told to.
// ----------------------------------------------------------------------------
module lrpw_walk (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  lrpw_pkg::lrpw_item_t item,
	input  lrpw_pkg::lrpw_regs_t regs,
	output lrpw_pkg::lrpw_pixel_t pixel
);
	import lrpw_pkg::*;

	logic [COORD_BITS-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q, dx_q, dy_q;
	logic                  step_left_q, step_up_q, active_q;
	logic signed [ERR_BITS-1:0] err_q;
	logic [COLOR_BITS-1:0] color_q;

	logic [COORD_BITS-1:0] cx, cy, tx, ty, dx, dy;
	logic                  sl, su, emit, in_frame, at_end, move_x, move_y;
	logic signed [ERR_BITS-1:0] err, err_nxt;
	logic signed [ERR_BITS:0]   e2, dx_ext, dy_ext;
	logic [COLOR_BITS-1:0] lcolor, mapped;
	logic [2*COORD_BITS:0] index_full;
	logic [COORD_BITS-1:0] cx_nxt, cy_nxt;
	logic                  active_nxt;

	function automatic logic [COLOR_BITS-1:0] map_color(
		input logic [COLOR_BITS-1:0] c,
		input lrpw_regs_t r
	);
		logic [COLOR_BITS-1:0] res;
		if (c == COLOR_CODE_FG) begin
			if (r.override_color != '0) res = r.override_color;
			else if (r.text_color != '0) res = r.text_color;
			else res = WHITE_565;
		end else if (c == COLOR_CODE_BG) begin
			res = r.background_color;
		end else begin
			res = c;
		end
		return res;
	endfunction

	always_comb begin
		if (item.cmd == CMD_START) begin
			cx = item.x_start;
			cy = item.y_start;
			tx = item.x_end;
			ty = item.y_end;
			dx = (item.x_end >= item.x_start) ? item.x_end - item.x_start
				: item.x_start - item.x_end;
			dy = (item.y_end >= item.y_start) ? item.y_end - item.y_start
				: item.y_start - item.y_end;
			sl = !(item.x_start < item.x_end);
			su = !(item.y_start < item.y_end);
			err = signed'(ERR_BITS'(dx)) - signed'(ERR_BITS'(dy));
			lcolor = item.color;
			emit = 1'b1;
		end else begin
			cx = cur_x_q;
			cy = cur_y_q;
			tx = tgt_x_q;
			ty = tgt_y_q;
			dx = dx_q;
			dy = dy_q;
			sl = step_left_q;
			su = step_up_q;
			err = err_q;
			lcolor = color_q;
			emit = active_q;
		end

		in_frame = (cx < regs.frame_width) && (cy < regs.frame_height);
		at_end = (cx == tx) && (cy == ty);
		index_full = (2*COORD_BITS+1)'(cy) * (2*COORD_BITS+1)'(regs.frame_width)
			+ (2*COORD_BITS+1)'(cx);
		mapped = map_color(lcolor, regs);

		e2 = {err, 1'b0};
		dx_ext = signed'((ERR_BITS+1)'(dx));
		dy_ext = signed'((ERR_BITS+1)'(dy));
		move_x = e2 > -dy_ext;
		move_y = e2 < dx_ext;
		err_nxt = err;
		cx_nxt = cx;
		cy_nxt = cy;
		if (move_x) begin
			cx_nxt = sl ? cx - 1'b1 : cx + 1'b1;
		end
		if (move_y) begin
			cy_nxt = su ? cy - 1'b1 : cy + 1'b1;
		end
		case ({move_x, move_y})
			2'b10: err_nxt = err - signed'(ERR_BITS'(dy));
			2'b01: err_nxt = err + signed'(ERR_BITS'(dx));
			2'b11: err_nxt = err - signed'(ERR_BITS'(dy)) + signed'(ERR_BITS'(dx));
			default: err_nxt = err;
		endcase
		active_nxt = emit && !at_end;

		if (emit) begin
			pixel.pixel_x = cx;
			pixel.pixel_y = cy;
			pixel.pixel_index = in_frame ? index_full[INDEX_BITS-1:0] : '0;
			pixel.pixel_color = mapped;
			pixel.write_enable = in_frame;
			pixel.last = at_end;
			pixel.busy_res = !at_end;
		end else begin
			pixel = '0;
		end
	end

	// Only the activity flag needs a reset value for correct behavior, but
	// all walk state is cleared to match the idle state after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			tgt_x_q <= '0;
			tgt_y_q <= '0;
			dx_q <= '0;
			dy_q <= '0;
			step_left_q <= 1'b0;
			step_up_q <= 1'b0;
			err_q <= '0;
			color_q <= '0;
			active_q <= 1'b0;
		end else if (advance && emit) begin
			tgt_x_q <= tx;
			tgt_y_q <= ty;
			dx_q <= dx;
			dy_q <= dy;
			step_left_q <= sl;
			step_up_q <= su;
			color_q <= lcolor;
			active_q <= active_nxt;
			if (!at_end) begin
				cur_x_q <= cx_nxt;
				cur_y_q <= cy_nxt;
				err_q <= err_nxt;
			end else begin
				cur_x_q <= cx;
				cur_y_q <= cy;
				err_q <= err;
			end
		end
	end

endmodule

// File: sv/line_rasterizer_pixel_writer_core.sv
// ----------------------------------------------------------------------------
// line_rasterizer_pixel_writer_core: Bresenham line walker with pixel output
// Turns start and tick requests into frame-buffer pixel writes.
// ----------------------------------------------------------------------------
// The item channel takes one request per cycle unless the pixel receiver
// stalls. A start request (cmd high) loads two endpoints and a color, drops
// any line in progress and produces the first pixel; each tick request (cmd
// low) produces the next pixel of the line, and a tick with no line active
// produces an all-zero pixel. The pixel channel gives exactly one pixel
// request per item request. The cfg channel writes the frame size and the
// three colors by index; it is always ready and is meant to be used only
// while no request is in flight. The input register takes a request and the
// output register then takes the pixel built from it through one pass of
// walk logic (an 8x8 multiply-add for the index and one error update). The
// throughput is one request per cycle without a stall, since the walk state
// moves on as a request leaves the input register. When the pixel receiver
// stalls, the output register holds its pixel and the input register takes
// one more request before item ready drops. Reset empties both stages,
// clears the walk and loads a 160 by 80 frame with all colors zero.
// ----------------------------------------------------------------------------
module line_rasterizer_pixel_writer_core (
	input logic         clk,
	input logic         arst_n,
	lrpw_stream_if.sink   item,
	lrpw_stream_if.source pixel,
	lrpw_stream_if.sink   cfg
);
	import lrpw_pkg::*;

	lrpw_regs_t  regs;
	lrpw_item_t  item_s1;
	logic        valid_s1;
	lrpw_pixel_t pixel_s2;
	logic        valid_s2;
	lrpw_pixel_t walk_pixel;
	logic        advance;

	// Configuration registers.
	lrpw_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// The output register can take a new pixel when it is empty or its
	// current pixel is leaving; the input register then moves forward.
	assign advance = !valid_s2 || pixel.ready;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item.data;
		end
	end

	// Walk logic works on the request in the input register.
	lrpw_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (valid_s1 && advance),
		.item    (item_s1),
		.regs    (regs),
		.pixel   (walk_pixel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			pixel_s2 <= walk_pixel;
		end
	end

	assign pixel.valid = valid_s2;
	assign pixel.data = pixel_s2;

`ifndef SYNTHESIS
	// A pixel with its write enable set lies inside the configured frame.
	a_write_inside: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && pixel_s2.write_enable |->
			(pixel_s2.pixel_x < regs.frame_width) &&
			(pixel_s2.pixel_y < regs.frame_height))
		else $error("write enable set for a pixel outside the frame");

	// A clipped pixel carries a zero index.
	a_clip_index: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !pixel_s2.write_enable |-> pixel_s2.pixel_index == '0)
		else $error("clipped pixel with nonzero index");

	// The final pixel of a line never claims more pixels remain.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(pixel_s2.last && pixel_s2.busy_res))
		else $error("pixel marked both last and busy");

	// With both stages full and the receiver stalled, no request is taken.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !pixel.ready |-> !item.ready)
		else $error("item accepted while the pipeline is full and stalled");
`endif

endmodule
